@@ rtl/keypad_expression_evaluator_assert.svh @@
// assertion macros shared by the checker of the keypad expression evaluator
`ifndef KEYPAD_EXPRESSION_EVALUATOR_ASSERT_SVH
`define KEYPAD_EXPRESSION_EVALUATOR_ASSERT_SVH

// clocked property, switched off while reset is held
`define KEE_ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("keypad evaluator assertion failed");

// clocked property that is also checked during reset
`define KEE_ASSERT_CLK(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("keypad evaluator assertion failed during reset");

`endif

@@ rtl/kee_pkg.sv @@
// shared types, key codes, micro-operations and helpers of the keypad evaluator
`timescale 1ns / 1ps
`default_nettype none

package kee_pkg;

    localparam int unsigned KEE_MAX_KEYS = 16;

    localparam logic [7:0] KEY_ZERO   = 8'd48;
    localparam logic [7:0] KEY_PLUS   = 8'd43;
    localparam logic [7:0] KEY_MINUS  = 8'd45;
    localparam logic [7:0] KEY_TIMES  = 8'd42;
    localparam logic [7:0] KEY_DIVIDE = 8'd47;
    localparam logic [7:0] KEY_EQUALS = 8'd61;
    localparam logic [7:0] KEY_CLEAR  = 8'd99;
    localparam logic [7:0] KEY_DIGIT_LO = 8'd1;
    localparam logic [7:0] KEY_DIGIT_HI = 8'd9;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } t_op;

    typedef enum logic [1:0] {
        PH_START,
        PH_SIGN,
        PH_DIGITS
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK,
        ST_DIV_ZERO,
        ST_KEY_LIMIT
    } t_status;

    typedef enum logic [2:0] {
        KC_UNKNOWN,
        KC_DIGIT,
        KC_PLUS,
        KC_MINUS,
        KC_TIMES,
        KC_DIVIDE,
        KC_EQUALS,
        KC_CLEAR
    } t_key_class;

    // micro-operations driven by the control word into the datapath
    typedef enum logic [4:0] {
        U_NOP,
        U_LATCH,
        U_CLEAR,
        U_SAT,
        U_DIGIT,
        U_SIGN,
        U_COUNT,
        U_OPND,
        U_TERM_SET,
        U_OPA_SUM,
        U_OPA_TERM,
        U_ALU,
        U_DIV_INIT,
        U_DIV_STEP,
        U_DIV_DONE,
        U_DIV_ZERO,
        U_FOLD,
        U_SETP,
        U_EMIT
    } t_uop;

    // program steps of the sequencer
    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_CLR,
        S_SAT,
        S_DIG,
        S_SIGN,
        S_OPK,
        S_FIN,
        S_FIN2,
        S_FIN3,
        S_LR,
        S_MD,
        S_ARITH,
        S_ARITH2,
        S_DIVST,
        S_DIVLP,
        S_DIVEND,
        S_DZ,
        S_POST,
        S_POST2,
        S_FOLDK,
        S_SETP,
        S_EQ,
        S_EMIT
    } t_step;

    typedef struct packed {
        t_uop uop;
        logic take;
    } t_kee_ctl;

    typedef struct packed {
        t_key_class key_class;
        logic       in_valid;
        logic       count_full;
        logic       phase_start;
        logic       mode;
        logic       pend_muldiv;
        logic       pend_div;
        logic       opnd_zero;
        logic       div_more;
        logic       out_busy;
    } t_kee_cond;

    function automatic t_key_class key_class(input logic [7:0] key);
        t_key_class cls;
        if (key >= KEY_DIGIT_LO && key <= KEY_DIGIT_HI) begin
            cls = KC_DIGIT;
        end else begin
            unique case (key)
                KEY_ZERO:   cls = KC_DIGIT;
                KEY_PLUS:   cls = KC_PLUS;
                KEY_MINUS:  cls = KC_MINUS;
                KEY_TIMES:  cls = KC_TIMES;
                KEY_DIVIDE: cls = KC_DIVIDE;
                KEY_EQUALS: cls = KC_EQUALS;
                KEY_CLEAR:  cls = KC_CLEAR;
                default:    cls = KC_UNKNOWN;
            endcase
        end
        return cls;
    endfunction

endpackage

`default_nettype wire

@@ rtl/kee_if.sv @@
// valid/ready channel interfaces: configuration write, key input, result output
`timescale 1ns / 1ps
`default_nettype none

interface kee_cfg_if;
    logic valid;
    logic ready;
    logic eval_mode;
    modport source (output valid, output eval_mode, input ready);
    modport sink (input valid, input eval_mode, output ready);
endinterface

interface kee_key_if;
    logic       valid;
    logic       ready;
    logic [7:0] key_code;
    modport source (output valid, output key_code, input ready);
    modport sink (input valid, input key_code, output ready);
endinterface

interface kee_res_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] result_value;
    logic [1:0]        result_status;
    modport source (output valid, output result_value, output result_status, input ready);
    modport sink (input valid, input result_value, input result_status, output ready);
endinterface

`default_nettype wire

@@ rtl/kee_seq.sv @@
// microcode sequencer: step counter, control-word rom and jump logic
`timescale 1ns / 1ps
`default_nettype none

module kee_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  kee_pkg::t_kee_cond   i_cond,
    output kee_pkg::t_kee_ctl    o_ctl
);

    typedef enum logic [3:0] {
        JC_GOTO,
        JC_DISPATCH,
        JC_WAIT_IN,
        JC_WAIT_OUT,
        JC_IF_MODE,
        JC_IF_MULDIV,
        JC_IF_DIV,
        JC_IF_DIVZ,
        JC_IF_DMORE,
        JC_IF_EQ,
        JC_IF_KMULDIV
    } t_jc;

    typedef struct packed {
        kee_pkg::t_uop  uop;
        t_jc            jc;
        kee_pkg::t_step target;
    } t_uword;

    function automatic t_uword ucode(input kee_pkg::t_step step);
        t_uword w;
        unique case (step)
            kee_pkg::S_IDLE:   w = '{kee_pkg::U_LATCH,    JC_WAIT_IN,    kee_pkg::S_DECODE};
            kee_pkg::S_DECODE: w = '{kee_pkg::U_NOP,      JC_DISPATCH,   kee_pkg::S_IDLE};
            kee_pkg::S_CLR:    w = '{kee_pkg::U_CLEAR,    JC_GOTO,       kee_pkg::S_IDLE};
            kee_pkg::S_SAT:    w = '{kee_pkg::U_SAT,      JC_GOTO,       kee_pkg::S_IDLE};
            kee_pkg::S_DIG:    w = '{kee_pkg::U_DIGIT,    JC_GOTO,       kee_pkg::S_IDLE};
            kee_pkg::S_SIGN:   w = '{kee_pkg::U_SIGN,     JC_GOTO,       kee_pkg::S_IDLE};
            kee_pkg::S_OPK:    w = '{kee_pkg::U_COUNT,    JC_GOTO,       kee_pkg::S_FIN};
            kee_pkg::S_FIN:    w = '{kee_pkg::U_OPND,     JC_IF_MODE,    kee_pkg::S_LR};
            kee_pkg::S_FIN2:   w = '{kee_pkg::U_NOP,      JC_IF_MULDIV,  kee_pkg::S_MD};
            kee_pkg::S_FIN3:   w = '{kee_pkg::U_TERM_SET, JC_GOTO,       kee_pkg::S_POST};
            kee_pkg::S_LR:     w = '{kee_pkg::U_OPA_SUM,  JC_GOTO,       kee_pkg::S_ARITH};
            kee_pkg::S_MD:     w = '{kee_pkg::U_OPA_TERM, JC_GOTO,       kee_pkg::S_ARITH};
            kee_pkg::S_ARITH:  w = '{kee_pkg::U_NOP,      JC_IF_DIV,     kee_pkg::S_DIVST};
            kee_pkg::S_ARITH2: w = '{kee_pkg::U_ALU,      JC_GOTO,       kee_pkg::S_POST};
            kee_pkg::S_DIVST:  w = '{kee_pkg::U_DIV_INIT, JC_IF_DIVZ,    kee_pkg::S_DZ};
            kee_pkg::S_DIVLP:  w = '{kee_pkg::U_DIV_STEP, JC_IF_DMORE,   kee_pkg::S_DIVLP};
            kee_pkg::S_DIVEND: w = '{kee_pkg::U_DIV_DONE, JC_GOTO,       kee_pkg::S_POST};
            kee_pkg::S_DZ:     w = '{kee_pkg::U_DIV_ZERO, JC_GOTO,       kee_pkg::S_POST};
            kee_pkg::S_POST:   w = '{kee_pkg::U_NOP,      JC_IF_EQ,      kee_pkg::S_EQ};
            kee_pkg::S_POST2:  w = '{kee_pkg::U_NOP,      JC_IF_KMULDIV, kee_pkg::S_SETP};
            kee_pkg::S_FOLDK:  w = '{kee_pkg::U_FOLD,     JC_GOTO,       kee_pkg::S_SETP};
            kee_pkg::S_SETP:   w = '{kee_pkg::U_SETP,     JC_GOTO,       kee_pkg::S_IDLE};
            kee_pkg::S_EQ:     w = '{kee_pkg::U_FOLD,     JC_GOTO,       kee_pkg::S_EMIT};
            kee_pkg::S_EMIT:   w = '{kee_pkg::U_EMIT,     JC_WAIT_OUT,   kee_pkg::S_IDLE};
            default:           w = '{kee_pkg::U_NOP,      JC_GOTO,       kee_pkg::S_IDLE};
        endcase
        return w;
    endfunction

    kee_pkg::t_step r_pc;
    kee_pkg::t_step n_pc;
    kee_pkg::t_step step_inc;
    kee_pkg::t_step dispatch;
    t_uword         uw;
    logic           hold;
    logic           key_muldiv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= kee_pkg::S_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    always_comb begin
        uw         = ucode(r_pc);
        step_inc   = kee_pkg::t_step'(r_pc + 5'd1);
        key_muldiv = (i_cond.key_class == kee_pkg::KC_TIMES) ||
                     (i_cond.key_class == kee_pkg::KC_DIVIDE);

        // key dispatch: clear and equals first, then the key limit
        unique case (i_cond.key_class)
            kee_pkg::KC_CLEAR:   dispatch = kee_pkg::S_CLR;
            kee_pkg::KC_UNKNOWN: dispatch = kee_pkg::S_IDLE;
            kee_pkg::KC_EQUALS:  dispatch = kee_pkg::S_FIN;
            default: begin
                if (i_cond.count_full) begin
                    dispatch = kee_pkg::S_SAT;
                end else if (i_cond.key_class == kee_pkg::KC_DIGIT) begin
                    dispatch = kee_pkg::S_DIG;
                end else if (i_cond.key_class == kee_pkg::KC_MINUS && i_cond.phase_start) begin
                    dispatch = kee_pkg::S_SIGN;
                end else begin
                    dispatch = kee_pkg::S_OPK;
                end
            end
        endcase

        hold = 1'b0;
        n_pc = step_inc;
        unique case (uw.jc)
            JC_GOTO:     n_pc = uw.target;
            JC_DISPATCH: n_pc = dispatch;
            JC_WAIT_IN: begin
                if (i_cond.in_valid) begin
                    n_pc = uw.target;
                end else begin
                    hold = 1'b1;
                    n_pc = r_pc;
                end
            end
            JC_WAIT_OUT: begin
                if (i_cond.out_busy) begin
                    hold = 1'b1;
                    n_pc = r_pc;
                end else begin
                    n_pc = uw.target;
                end
            end
            JC_IF_MODE:    if (i_cond.mode) n_pc = uw.target;
            JC_IF_MULDIV:  if (i_cond.pend_muldiv) n_pc = uw.target;
            JC_IF_DIV:     if (i_cond.pend_div) n_pc = uw.target;
            JC_IF_DIVZ:    if (i_cond.opnd_zero) n_pc = uw.target;
            JC_IF_DMORE:   if (i_cond.div_more) n_pc = uw.target;
            JC_IF_EQ:      if (i_cond.key_class == kee_pkg::KC_EQUALS) n_pc = uw.target;
            JC_IF_KMULDIV: if (key_muldiv) n_pc = uw.target;
            default:       n_pc = kee_pkg::S_IDLE;
        endcase

        o_ctl.uop  = hold ? kee_pkg::U_NOP : uw.uop;
        o_ctl.take = (r_pc == kee_pkg::S_IDLE);
    end

endmodule

`default_nettype wire

@@ rtl/kee_dpath.sv @@
// evaluator datapath: expression state, alu, restoring divider and result register
`timescale 1ns / 1ps
`default_nettype none

module kee_dpath #(
    parameter int unsigned MAX_KEYS = kee_pkg::KEE_MAX_KEYS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  kee_pkg::t_kee_ctl  i_ctl,
    output kee_pkg::t_kee_cond o_cond,
    kee_cfg_if.sink            i_cfg,
    kee_key_if.sink            i_key,
    kee_res_if.source          o_res
);

    localparam int unsigned KCW = $clog2(MAX_KEYS + 2);
    localparam logic [KCW-1:0] CNT_MAX  = KCW'(MAX_KEYS);
    localparam logic [KCW-1:0] CNT_OVER = KCW'(MAX_KEYS + 1);
    localparam logic [KCW-1:0] CNT_ONE  = KCW'(1);

    // expression state
    logic              r_mode,     n_mode;
    logic [7:0]        r_sum,      n_sum;
    logic [7:0]        r_term,     n_term;
    kee_pkg::t_op      r_pend,     n_pend;
    logic              r_term_sub, n_term_sub;
    logic [7:0]        r_num,      n_num;
    logic              r_neg,      n_neg;
    kee_pkg::t_phase   r_phase,    n_phase;
    logic [KCW-1:0]    r_count,    n_count;
    logic              r_div_err,  n_div_err;
    logic              r_out_valid, n_out_valid;

    // working registers
    logic [7:0]        r_key,    n_key;
    logic [7:0]        r_a,      n_a;
    logic [7:0]        r_opnd,   n_opnd;
    logic              r_dst,    n_dst;
    logic [7:0]        r_dvd,    n_dvd;
    logic [7:0]        r_rem,    n_rem;
    logic [7:0]        r_dvs,    n_dvs;
    logic              r_qneg,   n_qneg;
    logic [2:0]        r_dcnt,   n_dcnt;
    logic signed [7:0] r_value,  n_value;
    logic [1:0]        r_status, n_status;

    kee_pkg::t_key_class key_cls;
    kee_pkg::t_op        key_op;
    kee_pkg::t_status    status;
    logic [3:0]          digit;
    logic [7:0]          operand;
    logic [7:0]          alu;
    logic [7:0]          mag_a;
    logic [7:0]          mag_b;
    logic [8:0]          rem_sh;
    logic [8:0]          rem_diff;
    logic                div_ge;
    logic [7:0]          quot;
    logic [7:0]          folded;
    logic                out_busy;
    logic                overflow;
    logic                do_clear;

    always_comb begin
        key_cls = kee_pkg::key_class(r_key);
        digit   = (r_key == kee_pkg::KEY_ZERO) ? 4'd0 : r_key[3:0];
        unique case (key_cls)
            kee_pkg::KC_PLUS:   key_op = kee_pkg::OP_ADD;
            kee_pkg::KC_MINUS:  key_op = kee_pkg::OP_SUB;
            kee_pkg::KC_TIMES:  key_op = kee_pkg::OP_MUL;
            kee_pkg::KC_DIVIDE: key_op = kee_pkg::OP_DIV;
            default:            key_op = kee_pkg::OP_NONE;
        endcase

        operand = r_neg ? (~r_num + 8'd1) : r_num;

        unique case (r_pend)
            kee_pkg::OP_ADD: alu = r_a + r_opnd;
            kee_pkg::OP_SUB: alu = r_a - r_opnd;
            kee_pkg::OP_MUL: alu = 8'(r_a * r_opnd);
            default:         alu = r_opnd;
        endcase

        mag_a    = r_a[7] ? (~r_a + 8'd1) : r_a;
        mag_b    = r_opnd[7] ? (~r_opnd + 8'd1) : r_opnd;
        rem_sh   = {r_rem, r_dvd[7]};
        rem_diff = rem_sh - {1'b0, r_dvs};
        div_ge   = (rem_sh >= {1'b0, r_dvs});
        quot     = r_qneg ? (~r_dvd + 8'd1) : r_dvd;

        folded   = r_term_sub ? (r_sum - r_term) : (r_sum + r_term);
        out_busy = r_out_valid && !o_res.ready;
        overflow = (r_count > CNT_MAX);

        if (overflow) begin
            status = kee_pkg::ST_KEY_LIMIT;
        end else if (r_div_err) begin
            status = kee_pkg::ST_DIV_ZERO;
        end else begin
            status = kee_pkg::ST_OK;
        end
    end

    always_comb begin
        n_mode      = i_cfg.valid ? i_cfg.eval_mode : r_mode;
        n_sum       = r_sum;
        n_term      = r_term;
        n_pend      = r_pend;
        n_term_sub  = r_term_sub;
        n_num       = r_num;
        n_neg       = r_neg;
        n_phase     = r_phase;
        n_count     = r_count;
        n_div_err   = r_div_err;
        n_out_valid = (r_out_valid && !o_res.ready);
        n_key       = r_key;
        n_a         = r_a;
        n_opnd      = r_opnd;
        n_dst       = r_dst;
        n_dvd       = r_dvd;
        n_rem       = r_rem;
        n_dvs       = r_dvs;
        n_qneg      = r_qneg;
        n_dcnt      = r_dcnt;
        n_value     = r_value;
        n_status    = r_status;
        do_clear    = 1'b0;

        unique case (i_ctl.uop)
            kee_pkg::U_NOP:   ;
            kee_pkg::U_LATCH: n_key = i_key.key_code;
            kee_pkg::U_CLEAR: do_clear = 1'b1;
            kee_pkg::U_SAT:   n_count = CNT_OVER;
            kee_pkg::U_DIGIT: begin
                n_num   = 8'(r_num * 8'd10 + {4'd0, digit});
                n_phase = kee_pkg::PH_DIGITS;
                n_count = r_count + CNT_ONE;
            end
            kee_pkg::U_SIGN: begin
                n_neg   = 1'b1;
                n_phase = kee_pkg::PH_SIGN;
                n_count = r_count + CNT_ONE;
            end
            kee_pkg::U_COUNT: n_count = r_count + CNT_ONE;
            kee_pkg::U_OPND: begin
                n_opnd  = operand;
                n_num   = 8'd0;
                n_neg   = 1'b0;
                n_phase = kee_pkg::PH_START;
            end
            kee_pkg::U_TERM_SET: n_term = r_opnd;
            kee_pkg::U_OPA_SUM: begin
                n_a   = r_sum;
                n_dst = 1'b0;
            end
            kee_pkg::U_OPA_TERM: begin
                n_a   = r_term;
                n_dst = 1'b1;
            end
            kee_pkg::U_ALU: begin
                if (r_dst) n_term = alu;
                else       n_sum  = alu;
            end
            kee_pkg::U_DIV_INIT: begin
                n_dvd  = mag_a;
                n_dvs  = mag_b;
                n_rem  = 8'd0;
                n_qneg = r_a[7] ^ r_opnd[7];
                n_dcnt = 3'd7;
            end
            kee_pkg::U_DIV_STEP: begin
                n_rem  = div_ge ? rem_diff[7:0] : rem_sh[7:0];
                n_dvd  = {r_dvd[6:0], div_ge};
                n_dcnt = r_dcnt - 3'd1;
            end
            kee_pkg::U_DIV_DONE: begin
                if (r_dst) n_term = quot;
                else       n_sum  = quot;
            end
            // dividend stays where it is
            kee_pkg::U_DIV_ZERO: n_div_err = 1'b1;
            kee_pkg::U_FOLD: begin
                if (!r_mode) begin
                    n_sum  = folded;
                    n_term = 8'd0;
                end
                n_term_sub = (key_cls == kee_pkg::KC_MINUS);
            end
            kee_pkg::U_SETP: n_pend = key_op;
            kee_pkg::U_EMIT: begin
                n_value     = (status == kee_pkg::ST_OK) ? r_sum : 8'd0;
                n_status    = status;
                n_out_valid = 1'b1;
                do_clear    = 1'b1;
            end
            default: ;
        endcase

        if (do_clear) begin
            n_sum      = 8'd0;
            n_term     = 8'd0;
            n_pend     = kee_pkg::OP_NONE;
            n_term_sub = 1'b0;
            n_num      = 8'd0;
            n_neg      = 1'b0;
            n_phase    = kee_pkg::PH_START;
            n_count    = '0;
            n_div_err  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b0;
            r_sum       <= 8'd0;
            r_term      <= 8'd0;
            r_pend      <= kee_pkg::OP_NONE;
            r_term_sub  <= 1'b0;
            r_num       <= 8'd0;
            r_neg       <= 1'b0;
            r_phase     <= kee_pkg::PH_START;
            r_count     <= '0;
            r_div_err   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mode      <= n_mode;
            r_sum       <= n_sum;
            r_term      <= n_term;
            r_pend      <= n_pend;
            r_term_sub  <= n_term_sub;
            r_num       <= n_num;
            r_neg       <= n_neg;
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_div_err   <= n_div_err;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_a      <= n_a;
        r_opnd   <= n_opnd;
        r_dst    <= n_dst;
        r_dvd    <= n_dvd;
        r_rem    <= n_rem;
        r_dvs    <= n_dvs;
        r_qneg   <= n_qneg;
        r_dcnt   <= n_dcnt;
        r_value  <= n_value;
        r_status <= n_status;
    end

    assign i_cfg.ready         = 1'b1;
    assign i_key.ready         = i_ctl.take;
    assign o_res.valid         = r_out_valid;
    assign o_res.result_value  = r_value;
    assign o_res.result_status = r_status;

    assign o_cond.key_class   = key_cls;
    assign o_cond.in_valid    = i_key.valid;
    assign o_cond.count_full  = (r_count >= CNT_MAX);
    assign o_cond.phase_start = (r_phase == kee_pkg::PH_START);
    assign o_cond.mode        = r_mode;
    assign o_cond.pend_muldiv = (r_pend == kee_pkg::OP_MUL) || (r_pend == kee_pkg::OP_DIV);
    assign o_cond.pend_div    = (r_pend == kee_pkg::OP_DIV);
    assign o_cond.opnd_zero   = (r_opnd == 8'd0);
    assign o_cond.div_more    = (r_dcnt != 3'd0);
    assign o_cond.out_busy    = out_busy;

endmodule

`default_nettype wire

@@ rtl/keypad_expression_evaluator.sv @@
// top level of the keypad expression evaluator: sequencer plus datapath
//
// keypad expression evaluator: takes one key code per request on i_key and builds
// signed 8-bit decimal operands (digits 1..9 and '0', a leading '-' as sign, wrap
// modulo 256) joined by + - * /; '=' returns one request on o_res with the value and
// a status (ok, division by zero, key limit exceeded) and clears the expression,
// 'c' clears without a result and unknown codes are ignored. i_cfg.eval_mode picks
// precedence evaluation (0) or strict left to right (1); write it only while idle.
// one key is handled at a time: i_key.ready is high only while the sequencer sits
// at its idle step. an over-limit key is dropped; an operator or '=' also runs
// the operand, arithmetic and fold steps, and a pending division adds the 8
// iterations of the shared restoring divider. o_res is a registered output, so a
// result can wait for its sink while the next keys are taken; only the next '='
// stalls on it.
// no clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none

module keypad_expression_evaluator #(
    parameter int unsigned MAX_KEYS = kee_pkg::KEE_MAX_KEYS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kee_cfg_if.sink   i_cfg,
    kee_key_if.sink   i_key,
    kee_res_if.source o_res
);

    // control word out of the rom, condition flags back from the datapath
    kee_pkg::t_kee_ctl  ctl;
    kee_pkg::t_kee_cond cond;

    kee_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cond  (cond),
        .o_ctl   (ctl)
    );

    // expression registers, alu and divider; key limit sized from MAX_KEYS
    kee_dpath #(
        .MAX_KEYS (MAX_KEYS)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .o_cond  (cond),
        .i_cfg   (i_cfg),
        .i_key   (i_key),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

@@ rtl/kee_checker.sv @@
// port-level checker of the keypad expression evaluator and its bind
`timescale 1ns / 1ps
`default_nettype none

`include "keypad_expression_evaluator_assert.svh"

module kee_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_key_valid,
    input logic              i_key_ready,
    input logic              i_res_valid,
    input logic              i_res_ready,
    input logic signed [7:0] i_res_value,
    input logic [1:0]        i_res_status
);

    logic       key_take;
    logic       res_err;
    logic       res_stall;
    logic [9:0] res_word;

    assign key_take  = i_key_valid && i_key_ready;
    assign res_err   = i_res_valid && (i_res_status != kee_pkg::ST_OK);
    assign res_stall = i_res_valid && !i_res_ready;
    assign res_word  = {i_res_value, i_res_status};

    // an error status never carries a value
    `KEE_ASSERT_RST(a_err_value_zero, i_clk, i_rst_n, res_err |-> i_res_value == 8'sd0)

    // one key at a time: no request taken right after another
    `KEE_ASSERT_RST(a_key_one_at_a_time, i_clk, i_rst_n, key_take |=> !i_key_ready)

    // a stalled result holds
    `KEE_ASSERT_RST(a_res_hold, i_clk, i_rst_n, res_stall |=> i_res_valid && $stable(res_word))

    // reset drops any pending result
    `KEE_ASSERT_CLK(a_res_reset, i_clk, !i_rst_n |=> !i_res_valid)

endmodule

bind keypad_expression_evaluator kee_checker u_kee_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_key_valid  (i_key.valid),
    .i_key_ready  (i_key.ready),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_res_value  (o_res.result_value),
    .i_res_status (o_res.result_status)
);

`default_nettype wire
